// ----- hw/rtl/sca_pkg.sv -----
// shared constants, types and key lookup functions for the scan code decoder
`default_nettype none
package sca_pkg;

    localparam int BUF_DEPTH = 128;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int BUF_CW    = $clog2(BUF_DEPTH + 1);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    localparam int ROM_ROWS = 59;

    localparam logic [7:0] RELEASE_BIT  = 8'h80;
    localparam logic [7:0] SC_CTRL      = 8'h1D;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_CAPS      = 8'h3A;
    localparam logic [7:0] SC_CTRL_UP   = 8'h9D;
    localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;

    typedef enum logic [1:0] {
        CMD_SCAN    = 2'd0,
        CMD_POP_OLD = 2'd1,
        CMD_POP_NEW = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       key_stored;
        logic       overflow;
        logic       ctrl_event;
        logic [7:0] fill_count;
    } result_t;

    // each row is {shifted, plain}
    localparam logic [15:0] KEY_ROM [0:ROM_ROWS-1] = '{
        16'h0000, 16'h001B, 16'h2131, 16'h4032, 16'h2333, 16'h2434,
        16'h2535, 16'h5E36, 16'h2637, 16'h2A38, 16'h2839, 16'h2930,
        16'h5F2D, 16'h2B3D, 16'h0008, 16'h0009, 16'h5171, 16'h5777,
        16'h4565, 16'h5272, 16'h5474, 16'h5979, 16'h5575, 16'h4969,
        16'h4F6F, 16'h5070, 16'h7B5B, 16'h7D5D, 16'h000A, 16'h0000,
        16'h4161, 16'h5373, 16'h4464, 16'h4666, 16'h4767, 16'h4868,
        16'h4A6A, 16'h4B6B, 16'h4C6C, 16'h3A3B, 16'h2227, 16'h7E60,
        16'h0000, 16'h7C5C, 16'h5A7A, 16'h5878, 16'h4363, 16'h5676,
        16'h4262, 16'h4E6E, 16'h4D6D, 16'h3C2C, 16'h3E2E, 16'h3F2F,
        16'h0000, 16'h0000, 16'h0000, 16'h0020, 16'h0000
    };

    function automatic logic [15:0] key_row(input logic [6:0] code);
        logic [15:0] row;
        row = 16'h0000;
        if (code < 7'(ROM_ROWS)) begin
            row = KEY_ROM[code[5:0]];
        end
        return row;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sca_ram.sv -----
// simple dual port ram, one write and one registered read port
`default_nettype none
module sca_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8,
    parameter int AW    = 7
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sca_outq.sv -----
// small result queue that decouples the receiver from the buffer pipeline
`default_nettype none
module sca_outq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  sca_pkg::result_t       push_data,
    output logic [sca_pkg::OQ_CW-1:0] occ,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sca_pkg::result_t       m_data
);
    import sca_pkg::*;

    result_t            entry [0:OQ_DEPTH-1];
    logic [OQ_AW-1:0]   head_reg, head_next;
    logic [OQ_AW-1:0]   tail_reg, tail_next;
    logic [OQ_CW-1:0]   occ_reg, occ_next;
    logic               pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (occ_reg != '0);
    assign m_data  = entry[head_reg];
    assign occ     = occ_reg;

    always_comb begin
        head_next = pop ? head_reg + 1'b1 : head_reg;
        tail_next = push ? tail_reg + 1'b1 : tail_reg;
        occ_next  = occ_reg + OQ_CW'(push) - OQ_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry[tail_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/scancode_to_ascii_key_fifo.sv -----
// Keyboard scan code decoder with a character ring buffer.
// Input channel (s_): s_command selects a scan code (s_scan_code is a set-1
// byte, bit 7 marks a release), a pop of the oldest character, a pop of
// the newest one or a no-op. Every input transfer gives exactly one result
// transfer on the m_ channel: the popped character with char_valid, the
// key_stored, overflow and ctrl_event flags, and the fill count after the
// item. Modifier state, ring indices and the count update in the cycle
// of the input transfer; the character store is a single-port-write,
// registered-read ram, so a pop's data arrives in the cycle after the
// transfer. The result then enters a four-entry output queue.
// Throughput: one item per cycle while the receiver keeps up; s_ready
// comes from registered occupancy of the pipeline stage and the output
// queue, never from m_ready. When the receiver stalls, the queue fills
// and s_ready drops while room is still left for the items already in
// flight; nothing is lost.
// Reset (aresetn, synchronous, active low) clears modifiers, indices,
// count and the queue; the store itself is not cleared, since only
// written entries are ever popped.
`default_nettype none
module scancode_to_ascii_key_fifo (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_command,
    input  wire logic [7:0] s_scan_code,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_char_out,
    output logic            m_char_valid,
    output logic            m_key_stored,
    output logic            m_overflow,
    output logic            m_ctrl_event,
    output logic [7:0]      m_fill_count
);
    import sca_pkg::*;

    logic [BUF_AW-1:0] rd_idx_reg, rd_idx_next;
    logic [BUF_AW-1:0] wr_idx_reg, wr_idx_next;
    logic [BUF_CW-1:0] count_reg, count_next;
    logic              lsh_reg, lsh_next;
    logic              rsh_reg, rsh_next;
    logic              caps_reg, caps_next;
    logic              ctrl_reg, ctrl_next;

    logic              v1_reg;
    result_t           res1_reg, res1_next;

    logic              accept;
    logic              is_make;
    logic [15:0]       row;
    logic [7:0]        ch;
    logic              ctrl_ev;
    logic              has_chars;
    logic              buf_full;
    logic              ram_we;
    logic              ram_re;
    logic [BUF_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic [BUF_AW-1:0] wr_dec;

    logic [OQ_CW-1:0]  oq_occ;
    result_t           oq_in;
    result_t           oq_out;

    // room for the in-flight item plus this one
    assign s_ready = (oq_occ + OQ_CW'(v1_reg)) <= OQ_CW'(OQ_DEPTH - 2);
    assign accept  = s_valid && s_ready;

    assign is_make   = !s_scan_code[7];
    assign row       = key_row(s_scan_code[6:0]);
    assign has_chars = (count_reg != '0);
    assign buf_full  = (count_reg >= BUF_CW'(BUF_DEPTH));
    assign wr_dec    = (wr_idx_reg == '0) ? BUF_AW'(BUF_DEPTH - 1) : wr_idx_reg - 1'b1;

    always_comb begin
        lsh_next    = lsh_reg;
        rsh_next    = rsh_reg;
        caps_next   = caps_reg;
        ctrl_next   = ctrl_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        count_next  = count_reg;
        ch          = 8'h00;
        ctrl_ev     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = rd_idx_reg;
        res1_next   = '0;

        if (accept) begin
            case (s_command)
                CMD_SCAN: begin
                    if (is_make) begin
                        if (s_scan_code == SC_CTRL) begin
                            ctrl_next = 1'b1;
                        end else if (s_scan_code == SC_CAPS) begin
                            caps_next = !caps_reg;
                        end else if (s_scan_code == SC_LSHIFT) begin
                            lsh_next = 1'b1;
                        end else if (s_scan_code == SC_RSHIFT) begin
                            rsh_next = 1'b1;
                        end

                        // lookup uses the modifier state after this code
                        if (lsh_next || rsh_next) begin
                            ch = caps_next ? to_lower(row[15:8]) : row[15:8];
                        end else if (caps_next) begin
                            ch = to_upper(row[7:0]);
                        end else if (ctrl_next) begin
                            ctrl_ev = 1'b1;
                        end else begin
                            ch = row[7:0];
                        end

                        if (ch != 8'h00) begin
                            if (buf_full) begin
                                res1_next.overflow = 1'b1;
                            end else begin
                                ram_we      = 1'b1;
                                wr_idx_next = (wr_idx_reg == BUF_AW'(BUF_DEPTH - 1))
                                              ? '0 : wr_idx_reg + 1'b1;
                                count_next  = count_reg + 1'b1;
                                res1_next.key_stored = 1'b1;
                            end
                        end
                        res1_next.ctrl_event = ctrl_ev;
                    end else begin
                        if (s_scan_code == SC_CTRL_UP) begin
                            ctrl_next = 1'b0;
                        end else if (s_scan_code == SC_LSHIFT_UP) begin
                            lsh_next = 1'b0;
                        end else if (s_scan_code == SC_RSHIFT_UP) begin
                            rsh_next = 1'b0;
                        end
                    end
                end
                CMD_POP_OLD: begin
                    if (has_chars) begin
                        ram_re      = 1'b1;
                        ram_raddr   = rd_idx_reg;
                        rd_idx_next = (rd_idx_reg == BUF_AW'(BUF_DEPTH - 1))
                                      ? '0 : rd_idx_reg + 1'b1;
                        count_next  = count_reg - 1'b1;
                        res1_next.char_valid = 1'b1;
                    end
                end
                CMD_POP_NEW: begin
                    if (has_chars) begin
                        ram_re      = 1'b1;
                        ram_raddr   = wr_dec;
                        wr_idx_next = wr_dec;
                        count_next  = count_reg - 1'b1;
                        res1_next.char_valid = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            res1_next.fill_count = 8'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            count_reg  <= '0;
            lsh_reg    <= 1'b0;
            rsh_reg    <= 1'b0;
            caps_reg   <= 1'b0;
            ctrl_reg   <= 1'b0;
            v1_reg     <= 1'b0;
        end else begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            count_reg  <= count_next;
            lsh_reg    <= lsh_next;
            rsh_reg    <= rsh_next;
            caps_reg   <= caps_next;
            ctrl_reg   <= ctrl_next;
            v1_reg     <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res1_reg <= res1_next;
        end
    end

    sca_ram #(
        .DEPTH (BUF_DEPTH),
        .WIDTH (8),
        .AW    (BUF_AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (ch),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pop data joins the rest of the result in the cycle after the transfer
    always_comb begin
        oq_in          = res1_reg;
        oq_in.char_out = res1_reg.char_valid ? ram_rdata : 8'h00;
    end

    sca_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (v1_reg),
        .push_data (oq_in),
        .occ       (oq_occ),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (oq_out)
    );

    assign m_char_out   = oq_out.char_out;
    assign m_char_valid = oq_out.char_valid;
    assign m_key_stored = oq_out.key_stored;
    assign m_overflow   = oq_out.overflow;
    assign m_ctrl_event = oq_out.ctrl_event;
    assign m_fill_count = oq_out.fill_count;

endmodule
`default_nettype wire

// ----- hw/rtl/sca_chk.sv -----
// port level checks for the scan code decoder, bound to the top level
`default_nettype none
module sca_chk (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_char_out,
    input wire logic       m_char_valid,
    input wire logic       m_key_stored,
    input wire logic       m_overflow,
    input wire logic       m_ctrl_event,
    input wire logic [7:0] m_fill_count
);
    import sca_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_out) && $stable(m_fill_count))
        else $error("result changed while stalled");

    // stored characters are never zero
    a_pop_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_valid |-> m_char_out != 8'h00)
        else $error("popped character is zero");

    // one outcome per item at most
    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_char_valid, m_key_stored, m_overflow, m_ctrl_event}))
        else $error("conflicting result flags");

    // a dropped key only happens on a full buffer
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_fill_count == 8'(BUF_DEPTH))
        else $error("overflow with room left");

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule

bind scancode_to_ascii_key_fifo sca_chk u_sca_chk (.*);
`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for the scan code decoder and its character ring buffer
module testbench;
    import sca_pkg::*;

    // result fields in port order, as the decoder model predicts them
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       stored;
        logic       ovf;
        logic       ctrl_ev;
        logic [7:0] fill;
    } key_result_t;

    // plain and shifted characters per make code, built independently of the rtl
    localparam logic [7:0] PLAIN_KEYS [0:ROM_ROWS-1] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00
    };
    localparam logic [7:0] SHIFTED_KEYS [0:ROM_ROWS-1] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h00, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_command = CMD_SCAN;
    logic [7:0] s_scan_code = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_char_out;
    logic       m_char_valid;
    logic       m_key_stored;
    logic       m_overflow;
    logic       m_ctrl_event;
    logic [7:0] m_fill_count;

    // decoder model state
    logic [7:0]        key_mem [0:BUF_DEPTH-1];
    logic [BUF_AW-1:0] oldest_idx = '0;
    logic [BUF_AW-1:0] next_idx = '0;
    int                chars_held = 0;
    bit                lshift_down = 0;
    bit                rshift_down = 0;
    bit                caps_on = 0;
    bit                ctrl_down = 0;

    key_result_t expected_keys [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic hold_off = 1'b0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  mismatch_count = 0;
    int  overflow_seen = 0;
    int  ctrl_events_seen = 0;

    scancode_to_ascii_key_fifo uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_scan_code (s_scan_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_out  (m_char_out),
        .m_char_valid(m_char_valid),
        .m_key_stored(m_key_stored),
        .m_overflow  (m_overflow),
        .m_ctrl_event(m_ctrl_event),
        .m_fill_count(m_fill_count)
    );

    always #4 aclk = ~aclk;

    // advances the model by one item and returns what the block should answer
    function automatic key_result_t decode_key(cmd_t cmd, logic [7:0] code);
        key_result_t r;
        logic [7:0]  ch;
        bit          in_table;
        r = '0;
        case (cmd)
            CMD_SCAN: begin
                if (!code[7]) begin
                    ch = 8'h00;
                    in_table = (code < 8'(ROM_ROWS));
                    if (code == SC_CTRL) ctrl_down = 1;
                    else if (code == SC_CAPS) caps_on = !caps_on;
                    else if (code == SC_LSHIFT) lshift_down = 1;
                    else if (code == SC_RSHIFT) rshift_down = 1;

                    if (lshift_down || rshift_down) begin
                        if (in_table) ch = SHIFTED_KEYS[code[5:0]];
                        // caps inverts the shifted letters back to lower case
                        if (caps_on && ch >= 8'h41 && ch <= 8'h5A) ch = ch + 8'd32;
                    end else if (caps_on) begin
                        if (in_table) ch = PLAIN_KEYS[code[5:0]];
                        if (ch >= 8'h61 && ch <= 8'h7A) ch = ch - 8'd32;
                    end else if (ctrl_down) begin
                        r.ctrl_ev = 1'b1;
                    end else if (in_table) begin
                        ch = PLAIN_KEYS[code[5:0]];
                    end

                    if (ch != 8'h00) begin
                        if (chars_held >= BUF_DEPTH) begin
                            r.ovf = 1'b1;
                        end else begin
                            key_mem[next_idx] = ch;
                            next_idx = next_idx + 1'b1;
                            chars_held++;
                            r.stored = 1'b1;
                        end
                    end
                end else begin
                    if (code == SC_CTRL_UP) ctrl_down = 0;
                    else if (code == SC_LSHIFT_UP) lshift_down = 0;
                    else if (code == SC_RSHIFT_UP) rshift_down = 0;
                end
            end
            CMD_POP_OLD: begin
                if (chars_held > 0) begin
                    r.ch = key_mem[oldest_idx];
                    oldest_idx = oldest_idx + 1'b1;
                    chars_held--;
                    r.valid = 1'b1;
                end
            end
            CMD_POP_NEW: begin
                if (chars_held > 0) begin
                    next_idx = next_idx - 1'b1;
                    r.ch = key_mem[next_idx];
                    chars_held--;
                    r.valid = 1'b1;
                end
            end
            default: ;
        endcase
        r.fill = chars_held[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch at result %0d: %s got %h expected %h",
                 results_checked, what, got, want);
        mismatch_count++;
    endtask

    // offers one item, waits for its transfer, then records the expected answer
    task automatic send_item(cmd_t cmd, logic [7:0] code);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_scan_code <= code;
        do @(posedge aclk); while (!s_ready);
        expected_keys.push_back(decode_key(cmd, code));
        items_sent++;
    endtask

    // one step of mostly well-formed typing, with pops, noise and stray commands
    task automatic send_random_key(int pop_pct);
        int         sel;
        logic [7:0] code;
        sel = $urandom_range(99);
        if (sel < pop_pct / 2) begin
            send_item(CMD_POP_OLD, 8'($urandom));
        end else if (sel < pop_pct) begin
            send_item(CMD_POP_NEW, 8'($urandom));
        end else if (sel < pop_pct + 5) begin
            case ($urandom_range(2))
                0: code = SC_CTRL;
                1: code = SC_LSHIFT;
                default: code = SC_RSHIFT;
            endcase
            send_item(CMD_SCAN, code);
        end else if (sel < pop_pct + 12) begin
            case ($urandom_range(2))
                0: code = SC_CTRL_UP;
                1: code = SC_LSHIFT_UP;
                default: code = SC_RSHIFT_UP;
            endcase
            send_item(CMD_SCAN, code);
        end else if (sel < pop_pct + 14) begin
            send_item(CMD_SCAN, SC_CAPS);
        end else if (sel < pop_pct + 16) begin
            send_item(CMD_NOP, 8'($urandom));
        end else if (sel < pop_pct + 20) begin
            send_item(CMD_SCAN, 8'($urandom));
        end else begin
            code = 8'($urandom_range(ROM_ROWS - 1));
            send_item(CMD_SCAN, code);
            if ($urandom_range(9) < 7) send_item(CMD_SCAN, code | RELEASE_BIT);
        end
    endtask

    task automatic test_directed();
        send_item(CMD_SCAN, 8'h00);      // empty table row
        send_item(CMD_SCAN, 8'h01);      // escape
        send_item(CMD_SCAN, 8'h02);
        send_item(CMD_SCAN, 8'h39);      // space
        send_item(CMD_SCAN, SC_CAPS);
        send_item(CMD_SCAN, 8'h10);      // caps alone uppercases
        send_item(CMD_SCAN, 8'h02);
        send_item(CMD_SCAN, SC_LSHIFT);  // modifier row holds no character
        send_item(CMD_SCAN, 8'h10);      // shift with caps lowercases
        send_item(CMD_SCAN, 8'h03);
        send_item(CMD_SCAN, SC_LSHIFT_UP);
        send_item(CMD_SCAN, SC_CAPS);
        send_item(CMD_SCAN, SC_CTRL);    // ctrl press flags its own event
        send_item(CMD_SCAN, 8'h1E);
        send_item(CMD_SCAN, 8'h3B);      // past the table, ctrl still flags
        send_item(CMD_SCAN, SC_RSHIFT);
        send_item(CMD_SCAN, 8'h7F);
        send_item(CMD_SCAN, SC_RSHIFT_UP);
        send_item(CMD_SCAN, SC_CTRL_UP);
        send_item(CMD_SCAN, 8'hFF);      // other releases are ignored
        send_item(CMD_SCAN, 8'h80);
        send_item(CMD_POP_NEW, 8'h00);
        send_item(CMD_POP_OLD, 8'hFF);
        send_item(CMD_NOP, 8'hFF);
        send_item(CMD_NOP, 8'h00);
    endtask

    // fill past capacity so keys drop, then drain from both ends into empty pops
    task automatic test_buffer_full();
        send_item(CMD_SCAN, SC_CTRL_UP);
        send_item(CMD_SCAN, SC_LSHIFT_UP);
        send_item(CMD_SCAN, SC_RSHIFT_UP);
        while (chars_held < BUF_DEPTH) send_item(CMD_SCAN, 8'($urandom_range(16, 25)));
        repeat (3) send_item(CMD_SCAN, 8'($urandom_range(30, 38)));
        while (chars_held > 0) begin
            if ($urandom_range(1)) send_item(CMD_POP_OLD, 8'($urandom));
            else send_item(CMD_POP_NEW, 8'($urandom));
        end
        send_item(CMD_POP_OLD, 8'h00);
        send_item(CMD_POP_NEW, 8'hFF);
    endtask

    task automatic test_random_typing(int steps);
        int pop_pct;
        pop_pct = 30;
        for (int i = 0; i < steps; i++) begin
            // vary the pop rate so the buffer swings between empty and full
            if (i % 50 == 0) pop_pct = $urandom_range(10, 60);
            send_random_key(pop_pct);
        end
    endtask

    // receiver stops for a long stretch while items keep coming
    task automatic test_receiver_stall();
        fork
            begin
                hold_off <= 1'b1;
                repeat (400) @(posedge aclk);
                hold_off <= 1'b0;
            end
            begin
                repeat (40) send_random_key(25);
            end
        join
    endtask

    // checks each result transfer against the oldest expected answer
    always @(posedge aclk) begin
        key_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_keys.size() == 0) begin
                report_mismatch("unexpected result, char_out", m_char_out, 8'h00);
            end else begin
                want = expected_keys.pop_front();
                if (m_char_out !== want.ch)
                    report_mismatch("char_out", m_char_out, want.ch);
                if (m_char_valid !== want.valid)
                    report_mismatch("char_valid", 8'(m_char_valid), 8'(want.valid));
                if (m_key_stored !== want.stored)
                    report_mismatch("key_stored", 8'(m_key_stored), 8'(want.stored));
                if (m_overflow !== want.ovf)
                    report_mismatch("overflow", 8'(m_overflow), 8'(want.ovf));
                if (m_ctrl_event !== want.ctrl_ev)
                    report_mismatch("ctrl_event", 8'(m_ctrl_event), 8'(want.ctrl_ev));
                if (m_fill_count !== want.fill)
                    report_mismatch("fill_count", m_fill_count, want.fill);
                if (want.ovf) overflow_seen++;
                if (want.ctrl_ev) ctrl_events_seen++;
            end
            results_checked++;
        end
        m_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results still expected", expected_keys.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 18;
        recv_idle_pct <= 73;
        test_directed();
        test_buffer_full();
        test_random_typing(250);

        send_idle_pct = 73;
        recv_idle_pct <= 18;
        test_random_typing(250);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        test_receiver_stall();
        test_random_typing(250);

        s_valid <= 1'b0;
        while (expected_keys.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("sent %0d items and checked %0d results under three idle patterns",
                 items_sent, results_checked);
        $display("with a full buffer, %0d dropped keys and %0d ctrl events",
                 overflow_seen, ctrl_events_seen);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sca_pkg.sv
hw/rtl/sca_ram.sv
hw/rtl/sca_outq.sv
hw/rtl/scancode_to_ascii_key_fifo.sv
hw/rtl/sca_chk.sv
tb/testbench.sv
